/* design/htfc_pkg.sv */
`timescale 1ns / 1ps

package htfc_pkg;

  // CRC-8 of the sensor frame: poly x^8+x^5+x^4+1, preset to all ones
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Frame layout
  localparam int unsigned DATA_W    = 40;
  localparam int unsigned RAW_W     = 20;
  localparam int unsigned HUM_W     = 14;
  localparam int unsigned TMP_W     = 15;
  localparam logic [2:0]  POS_IDLE  = 3'd0;
  localparam logic [2:0]  POS_FIRST = 3'd1;
  localparam logic [2:0]  POS_LAST  = 3'd6;

  // Scaling to hundredths: value = (raw * scale) >> 20, temperature offset
  localparam logic [13:0] HUM_SCALE  = 14'd10000;
  localparam logic [14:0] TMP_SCALE  = 15'd20000;
  localparam logic [14:0] TMP_OFFSET = 15'd5000;

  // Default depth of the frame queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // One finished frame as handed from the front to the back
  typedef struct packed {
    logic [7:0]        status;
    logic [DATA_W-1:0] data;
    logic              ok;
  } frame_rec_t;

  // One byte step of the CRC, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/htfc_front.sv */
`timescale 1ns / 1ps

module htfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_frame_start,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_check_crc,
  input  logic                q_full,
  output logic                q_push,
  output htfc_pkg::frame_rec_t q_rec
);
  import htfc_pkg::*;

  logic [2:0]        pos_r, pos_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [7:0]        status_r, status_nxt;
  logic              check_r;
  logic              take;

  // Hold off bytes only while the queue has no room for a finished frame
  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;

  // Walk the frame one word at a time
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    q_push     = 1'b0;
    q_rec      = '{status: status_r, data: data_r, ok: 1'b1};
    if (take) begin
      priority if (in_frame_start) begin
        status_nxt = in_data_byte;
        crc_nxt    = crc_byte(CRC_INIT, in_data_byte);
        data_nxt   = '0;
        pos_nxt    = POS_FIRST;
      end else if (pos_r == POS_IDLE) begin
        pos_nxt = POS_IDLE;
      end else if (pos_r >= POS_LAST) begin
        // CRC word closes the frame
        q_push   = 1'b1;
        q_rec.ok = (crc_r == in_data_byte);
        pos_nxt  = POS_IDLE;
      end else begin
        crc_nxt  = crc_byte(crc_r, in_data_byte);
        data_nxt = {data_r[DATA_W-9:0], in_data_byte};
        pos_nxt  = pos_r + 3'd1;
        // Without CRC checking the sixth word closes the frame
        if (pos_r == POS_LAST - 3'd1 && !check_r) begin
          q_push     = 1'b1;
          q_rec.data = data_nxt;
          pos_nxt    = POS_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_IDLE;
      crc_r    <= CRC_INIT;
      data_r   <= '0;
      status_r <= '0;
      check_r  <= 1'b1;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      data_r   <= data_nxt;
      status_r <= status_nxt;
      if (cfg_valid && cfg_ready) begin
        check_r <= cfg_check_crc;
      end
    end
  end

endmodule

/* design/htfc_queue.sv */
`timescale 1ns / 1ps

module htfc_queue #(
  parameter int unsigned DEPTH = htfc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  htfc_pkg::frame_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output htfc_pkg::frame_rec_t head_rec
);
  import htfc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  frame_rec_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_rec  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

/* design/htfc_back.sv */
`timescale 1ns / 1ps

module htfc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  htfc_pkg::frame_rec_t q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_status_byte,
  output logic [19:0]          out_humidity_raw,
  output logic [19:0]          out_temperature_raw,
  output logic [13:0]          out_humidity_centi,
  output logic signed [14:0]   out_temperature_centi,
  output logic                 out_crc_ok
);
  import htfc_pkg::*;

  logic [RAW_W-1:0]       hum_raw, tmp_raw;
  logic [RAW_W+HUM_W-1:0] hum_prod;
  logic [RAW_W+TMP_W-1:0] tmp_prod;

  // Product stage
  logic             a_valid_r;
  logic [7:0]       a_status_r;
  logic [RAW_W-1:0] a_hum_raw_r, a_tmp_raw_r;
  logic [HUM_W-1:0] a_hum_r;
  logic [TMP_W-1:0] a_tmp_r;
  logic             a_ok_r;
  logic             adv_a, adv_b;

  assign adv_b = !out_valid || !out_stall;
  assign adv_a = !a_valid_r || adv_b;
  assign q_pop = q_not_empty && adv_a;

  assign hum_raw  = q_rec.data[DATA_W-1 -: RAW_W];
  assign tmp_raw  = q_rec.data[RAW_W-1:0];
  assign hum_prod = hum_raw * HUM_SCALE;
  assign tmp_prod = tmp_raw * TMP_SCALE;

  // Scale to hundredths: keep the bits above 2^20
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_status_r  <= q_rec.status;
      a_hum_raw_r <= hum_raw;
      a_tmp_raw_r <= tmp_raw;
      a_hum_r     <= hum_prod[RAW_W+HUM_W-1:RAW_W];
      a_tmp_r     <= tmp_prod[RAW_W+TMP_W-1:RAW_W];
      a_ok_r      <= q_rec.ok;
    end
  end

  // Apply offset, zero the scaled values on a CRC failure
  always_ff @(posedge clk) begin
    if (adv_b && a_valid_r) begin
      out_status_byte       <= a_status_r;
      out_humidity_raw      <= a_hum_raw_r;
      out_temperature_raw   <= a_tmp_raw_r;
      out_humidity_centi    <= a_ok_r ? a_hum_r : '0;
      out_temperature_centi <= a_ok_r ? $signed(a_tmp_r - TMP_OFFSET) : '0;
      out_crc_ok            <= a_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_r <= q_not_empty;
      end
      if (adv_b) begin
        out_valid <= a_valid_r;
      end
    end
  end

endmodule

/* design/humidity_temperature_frame_check.sv */
`timescale 1ns / 1ps

// Sensor frame checker: takes one frame word per cycle (status, five data
// words, then a CRC word when check_crc is 1), runs CRC-8 (0x31, preset 0xFF)
// and gives one result per frame with the raw 20-bit humidity and temperature
// codes and their values in hundredths. Words are taken back to back, one per
// cycle; in_stall rises only when the frame queue (QUEUE_DEPTH entries) is full
// because results are not being taken. A result moves through registers in order:
// the edge that takes the word closing its frame writes the queue, then the
// scaling multipliers are registered, then the output register is loaded, and
// out_stall can hold it in between. check_crc is read when the sixth word arrives.
module humidity_temperature_frame_check #(
  parameter int unsigned QUEUE_DEPTH = htfc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_frame_start,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_check_crc,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_status_byte,
  output logic [19:0]         out_humidity_raw,
  output logic [19:0]         out_temperature_raw,
  output logic [13:0]         out_humidity_centi,
  output logic signed [14:0]  out_temperature_centi,
  output logic                out_crc_ok
);
  import htfc_pkg::*;

  logic       q_full, q_push, q_pop, q_not_empty;
  frame_rec_t push_rec, head_rec;

  // Classify words and assemble frames
  htfc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_check_crc  (cfg_check_crc),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (push_rec)
  );

  // Buffer finished frames
  htfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  // Scale and deliver results
  htfc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_not_empty           (q_not_empty),
    .q_rec                 (head_rec),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status_byte       (out_status_byte),
    .out_humidity_raw      (out_humidity_raw),
    .out_temperature_raw   (out_temperature_raw),
    .out_humidity_centi    (out_humidity_centi),
    .out_temperature_centi (out_temperature_centi),
    .out_crc_ok            (out_crc_ok)
  );

endmodule
